>>> rtl/lzwe_pkg.sv
// ----------------------------------------------------------------------------
// lzwe_pkg
// Shared types and constants of the lzw byte encoder: request structs, the
// dictionary entry layout and the hash of a (prefix, byte) pair.
// ----------------------------------------------------------------------------
package lzwe_pkg;

  localparam int CODE_BITS  = 12;
  localparam int BYTE_BITS  = 8;
  localparam int KEY_BITS   = CODE_BITS + BYTE_BITS;
  localparam int EPOCH_BITS = 8;
  localparam int FIRST_FREE = 256;
  localparam int CODE_LIMIT = 1 << CODE_BITS;
  localparam int HASH_SHIFT = 5;
  localparam int HASH_BITS  = (CODE_BITS > BYTE_BITS + HASH_SHIFT) ?
                              CODE_BITS : BYTE_BITS + HASH_SHIFT;

  typedef struct packed {
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    logic                 last_code;
  } code_req_t;

  typedef struct packed {
    logic [EPOCH_BITS-1:0] epoch;
    logic [KEY_BITS-1:0]   key;
    logic [CODE_BITS-1:0]  code;
  } dict_entry_t;

  typedef struct packed {
    logic [1:0] num;
    code_req_t  first;
    code_req_t  second;
  } code_push_t;

  function automatic logic [HASH_BITS-1:0] dict_hash(
    input logic [CODE_BITS-1:0] prefix,
    input logic [BYTE_BITS-1:0] data_byte
  );
    dict_hash = (HASH_BITS'(data_byte) << HASH_SHIFT) ^ HASH_BITS'(prefix);
  endfunction

endpackage

>>> rtl/lzw_byte_encoder_unit.sv
// ----------------------------------------------------------------------------
// lzw_byte_encoder_unit
// LZW encoder for byte streams with 12-bit codes and a hashed dictionary
// ----------------------------------------------------------------------------
// byte channel: one byte per request, last_byte closes the stream.
// code channel: emitted codes in order, last_code marks the stream's final
//   code. a byte yields zero, one or two codes.
// a byte that opens a phrase is taken in ST_IDLE alone. any other byte goes
//   on to ST_PROBE, which steps through the dictionary: the dictionary ram
//   is read once per probe step and its read is registered.
// codes leave through a four-entry queue; a byte is taken only while the
//   queue has room for two codes, so a stalled receiver holds back input
//   once three codes wait.
// dictionary entries carry a stream tag; ending a stream bumps the tag.
// after reset, and after every 255 streams when the tag wraps, a clearing
//   pass writes every slot, with byte_stall high.
// HASH_SLOTS is a power of two.
// ----------------------------------------------------------------------------
module lzw_byte_encoder_unit #(
  parameter int HASH_SLOTS = 8192
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  lzwe_pkg::byte_req_t byte_item,
  output logic                code_valid,
  input  logic                code_stall,
  output lzwe_pkg::code_req_t code_item
);

  localparam int ADDR_BITS  = $clog2(HASH_SLOTS);
  localparam int ENTRY_BITS = $bits(lzwe_pkg::dict_entry_t);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_PROBE = 3'b100
  } state_t;

  state_t                              state, state_next;
  logic [lzwe_pkg::EPOCH_BITS-1:0]     epoch, epoch_next;
  logic [lzwe_pkg::CODE_BITS-1:0]      prefix, prefix_next;
  logic                                prefix_valid, prefix_valid_next;
  logic [lzwe_pkg::CODE_BITS:0]        next_free, next_free_next;
  logic [ADDR_BITS-1:0]                probe_addr, probe_addr_next;
  logic [ADDR_BITS-1:0]                probe_cnt, probe_cnt_next;
  logic [ADDR_BITS-1:0]                clear_addr, clear_addr_next;
  logic [lzwe_pkg::BYTE_BITS-1:0]      cur_byte;
  logic                                cur_last;

  logic                                accept;
  logic                                room2;
  logic                                end_stream;
  logic [ADDR_BITS-1:0]                hash_addr;
  logic [ADDR_BITS-1:0]                step_addr;
  logic [lzwe_pkg::KEY_BITS-1:0]       cur_key;
  logic                                slot_live, slot_match, slot_more;
  logic [lzwe_pkg::CODE_BITS-1:0]      byte_code, in_code;
  lzwe_pkg::code_push_t                push;
  lzwe_pkg::dict_entry_t               wr_data, rd_data;
  logic [ENTRY_BITS-1:0]               rd_bits;
  logic                                wr_en, rd_en;
  logic [ADDR_BITS-1:0]                wr_addr, rd_addr;

  assign accept     = byte_valid && !byte_stall;
  assign byte_stall = !((state == ST_IDLE) && room2);
  assign hash_addr  = ADDR_BITS'(lzwe_pkg::dict_hash(prefix, byte_item.data_byte));
  assign step_addr  = ADDR_BITS'(probe_addr + 1'b1);
  assign cur_key    = {prefix, cur_byte};
  assign rd_data    = lzwe_pkg::dict_entry_t'(rd_bits);
  assign slot_live  = (rd_data.epoch == epoch);
  assign slot_match = slot_live && (rd_data.key == cur_key);
  assign slot_more  = slot_live && !slot_match && (probe_cnt != '1);
  assign byte_code  = lzwe_pkg::CODE_BITS'(cur_byte);
  assign in_code    = lzwe_pkg::CODE_BITS'(byte_item.data_byte);

  always_comb begin
    state_next        = state;
    epoch_next        = epoch;
    prefix_next       = prefix;
    prefix_valid_next = prefix_valid;
    next_free_next    = next_free;
    probe_addr_next   = probe_addr;
    probe_cnt_next    = probe_cnt;
    clear_addr_next   = clear_addr;
    push              = '0;
    wr_en             = 1'b0;
    wr_addr           = probe_addr;
    wr_data           = '0;
    rd_en             = 1'b0;
    rd_addr           = hash_addr;
    end_stream        = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        wr_en           = 1'b1;
        wr_addr         = clear_addr;
        clear_addr_next = ADDR_BITS'(clear_addr + 1'b1);
        if (clear_addr == '1) begin
          state_next = ST_IDLE;
          epoch_next = lzwe_pkg::EPOCH_BITS'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (!prefix_valid) begin
            prefix_next       = in_code;
            prefix_valid_next = 1'b1;
            if (byte_item.last_byte) begin
              push.num   = 2'd1;
              push.first = '{code: in_code, last_code: 1'b1};
              end_stream = 1'b1;
            end
          end else begin
            rd_en           = 1'b1;
            probe_addr_next = hash_addr;
            probe_cnt_next  = '0;
            state_next      = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (slot_match) begin
          prefix_next = rd_data.code;
          state_next  = ST_IDLE;
          if (cur_last) begin
            push.num   = 2'd1;
            push.first = '{code: rd_data.code, last_code: 1'b1};
            end_stream = 1'b1;
          end
        end else if (slot_more) begin
          rd_en           = 1'b1;
          rd_addr         = step_addr;
          probe_addr_next = step_addr;
          probe_cnt_next  = ADDR_BITS'(probe_cnt + 1'b1);
        end else begin
          push.num    = 2'd1;
          push.first  = '{code: prefix, last_code: 1'b0};
          prefix_next = byte_code;
          state_next  = ST_IDLE;
          if (!slot_live &&
              (next_free < (lzwe_pkg::CODE_BITS + 1)'(lzwe_pkg::CODE_LIMIT))) begin
            wr_en          = 1'b1;
            wr_data        = '{epoch: epoch, key: cur_key,
                               code: next_free[lzwe_pkg::CODE_BITS-1:0]};
            next_free_next = next_free + 1'b1;
          end
          if (cur_last) begin
            push.num    = 2'd2;
            push.second = '{code: byte_code, last_code: 1'b1};
            end_stream  = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    if (end_stream) begin
      prefix_next       = '0;
      prefix_valid_next = 1'b0;
      next_free_next    = (lzwe_pkg::CODE_BITS + 1)'(lzwe_pkg::FIRST_FREE);
      if (epoch == '1) begin
        state_next      = ST_CLEAR;
        clear_addr_next = '0;
      end else begin
        epoch_next = epoch + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      epoch        <= lzwe_pkg::EPOCH_BITS'(1);
      prefix       <= '0;
      prefix_valid <= 1'b0;
      next_free    <= (lzwe_pkg::CODE_BITS + 1)'(lzwe_pkg::FIRST_FREE);
      probe_addr   <= '0;
      probe_cnt    <= '0;
      clear_addr   <= '0;
    end else begin
      state        <= state_next;
      epoch        <= epoch_next;
      prefix       <= prefix_next;
      prefix_valid <= prefix_valid_next;
      next_free    <= next_free_next;
      probe_addr   <= probe_addr_next;
      probe_cnt    <= probe_cnt_next;
      clear_addr   <= clear_addr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= byte_item.data_byte;
      cur_last <= byte_item.last_byte;
    end
  end

  lzwe_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (HASH_SLOTS)
  ) u_dict (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  lzwe_out_fifo u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room2      (room2),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
  );

endmodule

>>> rtl/lzwe_ram.sv
// ----------------------------------------------------------------------------
// lzwe_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read.
// ----------------------------------------------------------------------------
module lzwe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/lzwe_out_fifo.sv
// ----------------------------------------------------------------------------
// lzwe_out_fifo
// Four-entry code queue; takes up to two codes per cycle and hands them to
// the output channel one at a time.
// ----------------------------------------------------------------------------
module lzwe_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  lzwe_pkg::code_push_t push,
  output logic                room2,
  output logic                code_valid,
  input  logic                code_stall,
  output lzwe_pkg::code_req_t code_item
);

  lzwe_pkg::code_req_t mem [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop        = code_valid && !code_stall;
  assign code_valid = (count != 3'd0);
  assign code_item  = mem[rd_ptr];
  assign room2      = (count <= 3'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.num;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(push.num) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.num == 2'd2) begin
      mem[2'(wr_ptr + 2'd1)] <= push.second;
    end
  end

endmodule

>>> rtl/lzwe_checker.sv
// ----------------------------------------------------------------------------
// lzwe_checker
// Port-level checks of the lzw byte encoder, bound to its top level.
// ----------------------------------------------------------------------------
module lzwe_checker (
  input logic                clk,
  input logic                rst,
  input logic                byte_valid,
  input logic                byte_stall,
  input lzwe_pkg::byte_req_t byte_item,
  input logic                code_valid,
  input logic                code_stall,
  input lzwe_pkg::code_req_t code_item
);

  // stalled code request holds
  assert property (@(posedge clk) disable iff (rst)
    code_valid && code_stall |=> code_valid && $stable(code_item))
    else $error("stalled code request changed");

  // clearing pass follows reset
  assert property (@(posedge clk) rst |=> byte_stall)
    else $error("byte taken right after reset");

  // queue empty after reset
  assert property (@(posedge clk) rst |=> !code_valid)
    else $error("code offered right after reset");

  // stalled byte request holds
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_stall |=> byte_valid && $stable(byte_item))
    else $error("stalled byte request changed");

endmodule

bind lzw_byte_encoder_unit lzwe_checker u_lzwe_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .byte_item  (byte_item),
  .code_valid (code_valid),
  .code_stall (code_stall),
  .code_item  (code_item)
);

>>> tb/tb_lzw_byte_encoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lzw_byte_encoder_unit
// Self-checking bench for the lzw byte encoder. A queue of byte requests,
// built up front from short directed streams, random streams of several
// shapes and a run of tiny streams that wraps the stream tag, feeds a
// clocked driver. Each accepted byte goes through a behavioral encoder with
// its own hashed dictionary, which queues the codes due. A clocked monitor
// compares every code request with the oldest due code, field by field.
// Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_lzw_byte_encoder_unit;

  localparam int HASH_SLOTS  = 8192;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    lzwe_pkg::byte_req_t req;
    logic                wait_drain;
  } byte_job_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                byte_valid = 1'b0;
  logic                byte_stall;
  lzwe_pkg::byte_req_t byte_item = '0;
  logic                code_valid;
  logic                code_stall = 1'b0;
  lzwe_pkg::code_req_t code_item;

  byte_job_t           bytes_to_send[$];
  lzwe_pkg::code_req_t codes_due[$];

  // encoder state
  int                            slot_tag [HASH_SLOTS];
  logic [lzwe_pkg::KEY_BITS-1:0]  slot_key [HASH_SLOTS];
  logic [lzwe_pkg::CODE_BITS-1:0] slot_code [HASH_SLOTS];
  logic [lzwe_pkg::CODE_BITS-1:0] phrase_code = '0;
  bit                            phrase_open = 1'b0;
  int                            next_code = lzwe_pkg::FIRST_FREE;
  int                            stream_no = 0;

  int  n_predicted = 0;
  int  n_codes = 0;
  int  n_bytes = 0;
  int  n_errors = 0;
  int  n_cycles = 0;
  int  n_streams_built = 0;
  int  send_gap = 0;
  int  send_level = 0;
  int  stall_left = 0;
  int  recv_level = 0;
  bit  tail_phase = 1'b0;
  lzwe_pkg::code_req_t want;
  byte_job_t job;

  lzw_byte_encoder_unit #(.HASH_SLOTS(HASH_SLOTS)) uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_item  (code_item)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic bit chance(input int level);
    case (level)
      0:       chance = 1'b0;
      1:       chance = ($urandom_range(0, 19) == 0);
      2:       chance = ($urandom_range(0, 4) == 0);
      default: chance = ($urandom_range(0, 1) == 0);
    endcase
  endfunction

  function automatic void queue_code(input logic [lzwe_pkg::CODE_BITS-1:0] c,
                                     input logic last);
    lzwe_pkg::code_req_t r;
    r.code      = c;
    r.last_code = last;
    codes_due = {codes_due, r};
    n_predicted++;
  endfunction

  // expected codes for one accepted byte
  function automatic void encode_byte(input lzwe_pkg::byte_req_t req);
    logic [lzwe_pkg::KEY_BITS-1:0] key;
    int idx;
    int slot;
    int n;
    bit hit;
    if (!phrase_open) begin
      phrase_code = lzwe_pkg::CODE_BITS'(req.data_byte);
      phrase_open = 1'b1;
    end else begin
      key  = {phrase_code, req.data_byte};
      idx  = ((int'(req.data_byte) << 5) ^ int'(phrase_code)) % HASH_SLOTS;
      slot = -1;
      hit  = 1'b0;
      for (n = 0; n < HASH_SLOTS; n++) begin
        if (slot_tag[idx] != stream_no) begin
          slot = idx;
          break;
        end
        if (slot_key[idx] == key) begin
          slot = idx;
          hit  = 1'b1;
          break;
        end
        idx = (idx + 1) % HASH_SLOTS;
      end
      if (hit) begin
        phrase_code = slot_code[slot];
      end else begin
        queue_code(phrase_code, 1'b0);
        if (slot >= 0 && next_code < lzwe_pkg::CODE_LIMIT) begin
          slot_tag[slot]  = stream_no;
          slot_key[slot]  = key;
          slot_code[slot] = lzwe_pkg::CODE_BITS'(next_code);
          next_code++;
        end
        phrase_code = lzwe_pkg::CODE_BITS'(req.data_byte);
      end
    end
    if (req.last_byte) begin
      queue_code(phrase_code, 1'b1);
      stream_no++;
      phrase_open = 1'b0;
      phrase_code = '0;
      next_code   = lzwe_pkg::FIRST_FREE;
    end
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic last, input logic drain);
    byte_job_t j;
    j.req.data_byte = b;
    j.req.last_byte = last;
    j.wait_drain    = drain;
    bytes_to_send = {bytes_to_send, j};
  endtask

  // shape 0: random bytes, 1: small alphabet, 2: repeated motif with noise,
  // 3: mostly random with some bytes from a small alphabet
  task automatic add_stream(input int shape, input int len, input bit drain_first);
    logic [7:0] base;
    logic [7:0] b;
    logic [7:0] motif [4];
    int mlen;
    int i;
    base = 8'($urandom_range(0, 255));
    mlen = $urandom_range(1, 4);
    for (i = 0; i < 4; i++) motif[i] = 8'($urandom_range(0, 255));
    for (i = 0; i < len; i++) begin
      case (shape)
        0: b = 8'($urandom_range(0, 255));
        1: b = base ^ 8'($urandom_range(0, 2));
        2: b = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : motif[i % mlen];
        default: b = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 255)) :
                     base ^ 8'($urandom_range(0, 3));
      endcase
      add_byte(b, i == len - 1, drain_first && i == 0);
    end
    n_streams_built++;
  endtask

  task automatic add_random_streams(input int n_items, input bit drain_first);
    int n_gen;
    int pick;
    bit first;
    n_gen = 0;
    first = drain_first;
    while (n_gen < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) begin
        add_stream(0, $urandom_range(1, 2), first);
        n_gen += 2;
      end else if (pick < 6) begin
        add_stream(1, $urandom_range(3, 40), first);
        n_gen += 20;
      end else if (pick < 8) begin
        add_stream(2, $urandom_range(2, 40), first);
        n_gen += 20;
      end else begin
        add_stream(3, $urandom_range(2, 20), first);
        n_gen += 10;
      end
      first = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (byte_valid && !byte_stall) begin
        encode_byte(byte_item);
        n_bytes++;
        if (n_bytes % 64 == 0) send_level = $urandom_range(0, 3);
        if (!tail_phase && chance(send_level)) send_gap = $urandom_range(1, 15);
      end
      if (!byte_valid || !byte_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          byte_valid <= 1'b0;
        end else if (bytes_to_send.size() > 0 &&
                     !(bytes_to_send[0].wait_drain && n_codes < n_predicted)) begin
          job = bytes_to_send.pop_front();
          byte_valid <= 1'b1;
          byte_item  <= job.req;
        end else begin
          byte_valid <= 1'b0;
        end
      end
      tail_phase <= (bytes_to_send.size() < 150);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      code_stall <= 1'b0;
    end else begin
      if (code_valid && !code_stall) begin
        if (codes_due.size() == 0) begin
          $display("%0t: unexpected code request, expected none, got code %0d last %0b",
                   $time, code_item.code, code_item.last_code);
          n_errors++;
        end else begin
          want = codes_due.pop_front();
          if (code_item.code !== want.code) begin
            $display("%0t: code mismatch, expected %0d, got %0d",
                     $time, want.code, code_item.code);
            n_errors++;
          end
          if (code_item.last_code !== want.last_code) begin
            $display("%0t: last_code mismatch, expected %0b, got %0b",
                     $time, want.last_code, code_item.last_code);
            n_errors++;
          end
        end
        n_codes <= n_codes + 1;
      end
      if (n_cycles % 100 == 0) recv_level = $urandom_range(0, 3);
      if (stall_left > 0) begin
        stall_left--;
        code_stall <= 1'b1;
      end else if (!tail_phase && chance(recv_level)) begin
        stall_left = $urandom_range(0, 14);
        code_stall <= 1'b1;
      end else begin
        code_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < HASH_SLOTS; i++) slot_tag[i] = -1;

    // single-byte streams at both ends of the byte range
    add_byte(8'h00, 1'b1, 1'b0);
    add_byte(8'hFF, 1'b1, 1'b0);
    // alternating pair, phrases get lengthened
    for (i = 0; i < 7; i++) add_byte((i % 2) ? 8'h42 : 8'h41, i == 6, 1'b0);
    // two pairs that hash to the same slot
    add_byte(8'h41, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h61, 1'b0, 1'b0);
    add_byte(8'h01, 1'b1, 1'b0);
    // collision on the top slot, probe wraps to slot zero
    add_byte(8'h1F, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h3F, 1'b0, 1'b0);
    add_byte(8'hFE, 1'b1, 1'b0);
    // stream ending on a lengthened phrase
    add_byte(8'h7F, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0);
    add_byte(8'h80, 1'b1, 1'b0);

    add_random_streams(300, 1'b1);
    // enough streams to wrap the stream tag
    while (n_streams_built < 270) add_stream(0, $urandom_range(1, 2), 1'b0);
    add_random_streams(200, 1'b1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (bytes_to_send.size() > 0 || byte_valid || n_codes < n_predicted)
      @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d streams, %0d bytes sent, %0d codes checked",
             stream_no, n_bytes, n_codes);
    $display("covered hash collisions, probe wrap, stream tag wrap and clearing pass");
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
